[rtl/core/multiset_bag_table_unit_macros.svh]
// Assertion helpers used by the bag table unit.
`ifndef MULTISET_BAG_TABLE_UNIT_MACROS_SVH
`define MULTISET_BAG_TABLE_UNIT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define MBT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mbt_pkg.sv]
`timescale 1ns / 1ps

package mbt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int FIELD_W      = 5;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Control part of the probe that walks down the row of cells
    typedef struct packed {
        logic valid;
        logic remove;
        logic found;
    } probe_t;

    // Entry handed to the left neighbour while a removal closes the gap
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] data;
    } push_t;

endpackage

[rtl/core/mbt_cell.sv]
`timescale 1ns / 1ps

module mbt_cell
    import mbt_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   count,
    input  logic               add_en,
    input  logic [VALUE_W-1:0] add_value,
    input  probe_t             ctrl_in,
    input  logic [VALUE_W-1:0] value_in,
    input  logic [CNT_W-1:0]   freq_in,
    input  push_t              push_in,
    output probe_t             ctrl_out,
    output logic [VALUE_W-1:0] value_out,
    output logic [CNT_W-1:0]   freq_out,
    output push_t              push_out
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [VALUE_W-1:0] entry_reg;
    probe_t             ctrl_reg;
    probe_t             ctrl_next;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   freq_reg;
    logic [CNT_W-1:0]   freq_next;
    logic               active;
    logic               hit;

    // Only slots below the held count take part in a scan
    assign active = ctrl_in.valid && (IDX_C < count);
    assign hit    = active && (entry_reg == value_in);

    always_comb
    begin
        ctrl_next       = ctrl_in;
        ctrl_next.found = ctrl_in.found | hit;
        freq_next       = freq_in + CNT_W'(hit);
    end

    // Once the removed slot lies behind the probe, hand this entry one slot left
    assign push_out.valid = ctrl_in.valid && ctrl_in.remove && ctrl_in.found;
    assign push_out.data  = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_in;
        freq_reg  <= freq_next;
        if (add_en && (count == IDX_C))
        begin
            entry_reg <= add_value;
        end
        else if (push_in.valid)
        begin
            entry_reg <= push_in.data;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign value_out = value_reg;
    assign freq_out  = freq_reg;

endmodule

[rtl/core/multiset_bag_table_unit.sv]
`timescale 1ns / 1ps
// Channel | Signals                               | Direction
// input   | in_valid, in_stall, action, value     | item in, stall out
// output  | out_valid, out_stall, ok, frequency,  | result out, stall in
//         | size, empty_res                       |
//
// Add and clear go from IDLE straight to FINISH, which loads the output register.
// Remove and query send a probe down the row of CAPACITY cells, one cell a cycle;
// the outcome is taken from the probe as it leaves the last cell.
// Reset empties the table; entries themselves are not cleared.
// One item is in work at a time; the next transfer is taken once its result sits
// in the output register, even while out_stall holds that result.

module multiset_bag_table_unit
    import mbt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      ok,
    output logic [FIELD_W-1:0]        frequency,
    output logic [FIELD_W-1:0]        size,
    output logic                      empty_res
);

    `include "multiset_bag_table_unit_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               res_ok_reg, res_ok_next;
    logic [CNT_W-1:0]   res_freq_reg, res_freq_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [FIELD_W-1:0] freq_reg;
    logic [FIELD_W-1:0] size_reg;
    logic               empty_reg;

    logic               accept;
    logic               add_en;
    logic               out_load;
    action_t            act;
    logic [VALUE_W-1:0] value_u;

    probe_t             pc  [CAPACITY+1];
    logic [VALUE_W-1:0] pv  [CAPACITY];
    logic [CNT_W-1:0]   pf  [CAPACITY+1];
    push_t              psh [CAPACITY+1];
    probe_t             tail;

    function automatic logic [FIELD_W-1:0] sat_field(input logic [CNT_W-1:0] x);
        logic [FIELD_W-1:0] r;
        if (int'(x) > (2 ** FIELD_W) - 1)
        begin
            r = '1;
        end
        else
        begin
            r = FIELD_W'(x);
        end
        return r;
    endfunction

    assign act      = action_t'(action);
    assign value_u  = value;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign add_en   = accept && (act == ACT_ADD) && (count_reg < CAP_C);

    // Launch a probe into the head of the row for remove and query
    assign pc[0].valid  = accept && ((act == ACT_REMOVE) || (act == ACT_QUERY));
    assign pc[0].remove = (act == ACT_REMOVE);
    assign pc[0].found  = 1'b0;
    assign pv[0]        = value_u;
    assign pf[0]        = '0;
    assign psh[CAPACITY] = '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i < CAPACITY - 1)
            begin : g_mid
                mbt_cell #(
                    .CNT_W (CNT_W),
                    .IDX   (i)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .count     (count_reg),
                    .add_en    (add_en),
                    .add_value (value_u),
                    .ctrl_in   (pc[i]),
                    .value_in  (pv[i]),
                    .freq_in   (pf[i]),
                    .push_in   (psh[i+1]),
                    .ctrl_out  (pc[i+1]),
                    .value_out (pv[i+1]),
                    .freq_out  (pf[i+1]),
                    .push_out  (psh[i])
                );
            end
            else
            begin : g_last
                mbt_cell #(
                    .CNT_W (CNT_W),
                    .IDX   (i)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .count     (count_reg),
                    .add_en    (add_en),
                    .add_value (value_u),
                    .ctrl_in   (pc[i]),
                    .value_in  (pv[i]),
                    .freq_in   (pf[i]),
                    .push_in   (psh[i+1]),
                    .ctrl_out  (pc[i+1]),
                    .value_out (),
                    .freq_out  (pf[i+1]),
                    .push_out  (psh[i])
                );
            end
        end
    endgenerate

    assign tail     = pc[CAPACITY];
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        res_ok_next   = res_ok_reg;
        res_freq_next = res_freq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_freq_next = '0;
                    case (act)
                        ACT_ADD:
                        begin
                            res_ok_next = (count_reg < CAP_C);
                            if (count_reg < CAP_C)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        ACT_CLEAR:
                        begin
                            res_ok_next = 1'b1;
                            count_next  = '0;
                            state_next  = ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // The probe leaving the last cell carries the scan outcome
                if (tail.valid)
                begin
                    if (tail.remove)
                    begin
                        res_ok_next   = tail.found;
                        res_freq_next = '0;
                        if (tail.found)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        res_ok_next   = (pf[CAPACITY] != '0);
                        res_freq_next = pf[CAPACITY];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg   <= res_ok_next;
        res_freq_reg <= res_freq_next;
        if (out_load)
        begin
            ok_reg    <= res_ok_reg;
            freq_reg  <= sat_field(res_freq_reg);
            size_reg  <= sat_field(count_reg);
            empty_reg <= (count_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign frequency = freq_reg;
    assign size      = size_reg;
    assign empty_res = empty_reg;

    `MBT_ASSERT_ALWAYS(a_count_range, count_reg <= CAP_C,
        "held count beyond capacity")
    `MBT_ASSERT_ALWAYS(a_tail_in_scan, !tail.valid || (state_reg == ST_SCAN),
        "probe left the row outside a scan")
    `MBT_ASSERT_ALWAYS(a_no_head_push, !psh[0].valid,
        "entry shifted out of the head cell")
    `MBT_ASSERT_NEXT(a_remove_shrinks, tail.valid && tail.remove && tail.found,
        count_reg == $past(count_reg) - 1'b1, "successful remove did not shrink count")
    `MBT_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE,
        "transfer taken without starting work")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mbt_pkg::*;

    localparam int BAG_DEPTH = CAPACITY_DEF;
    localparam int FIELD_MAX = (1 << FIELD_W) - 1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int DRAIN_CYCLES = 2 * (BAG_DEPTH + 2);
    localparam int PLAN_ROWS = 18;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] freq;
        logic [FIELD_W-1:0] size;
        logic               empty;
    } bag_result_t;

    typedef struct {
        action_t     op;
        logic [31:0] val;
        int          reps;
        bit          typed;
        bag_result_t want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [1:0]                action = ACT_ADD;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      ok;
    logic [FIELD_W-1:0]        frequency;
    logic [FIELD_W-1:0]        size;
    logic                      empty_res;

    // shadow copy of the bag
    logic [31:0] bag_slots [BAG_DEPTH];
    int          bag_count = 0;

    bag_result_t awaited_results [$];
    plan_row_t   plan [PLAN_ROWS];
    logic [31:0] value_pool [8];

    bit calm = 1'b0;
    bit hold_wanted = 1'b0;
    int mismatches = 0;
    int results_checked = 0;
    int op_tally [4] = '{0, 0, 0, 0};
    int full_refusals = 0;
    int remove_misses = 0;
    int peak_fill = 0;

    multiset_bag_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .frequency (frequency),
        .size      (size),
        .empty_res (empty_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bag_result_t apply_bag_op(action_t op, logic [31:0] v);
        bag_result_t r;
        int          first_hit;
        int          hits;
        r = '0;
        first_hit = -1;
        hits = 0;
        for (int i = 0; i < bag_count; i++)
        begin
            if (bag_slots[i] == v)
            begin
                hits++;
                if (first_hit < 0)
                    first_hit = i;
            end
        end
        case (op)
            ACT_ADD:
            begin
                if (bag_count < BAG_DEPTH)
                begin
                    bag_slots[bag_count] = v;
                    bag_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                // fill the hole with the last entry
                if (first_hit >= 0)
                begin
                    bag_count--;
                    bag_slots[first_hit] = bag_slots[bag_count];
                    r.ok = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                r.freq = FIELD_W'((hits > FIELD_MAX) ? FIELD_MAX : hits);
                r.ok = (hits > 0);
            end
            default:
            begin
                bag_count = 0;
                r.ok = 1'b1;
            end
        endcase
        r.size = FIELD_W'((bag_count > FIELD_MAX) ? FIELD_MAX : bag_count);
        r.empty = (bag_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic check_result();
        bag_result_t exp_r;
        results_checked++;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with nothing awaited", 0, 0);
            return;
        end
        exp_r = awaited_results.pop_front();
        if (ok !== exp_r.ok)
            report_mismatch("ok", 32'(ok), 32'(exp_r.ok));
        if (frequency !== exp_r.freq)
            report_mismatch("frequency", 32'(frequency), 32'(exp_r.freq));
        if (size !== exp_r.size)
            report_mismatch("size", 32'(size), 32'(exp_r.size));
        if (empty_res !== exp_r.empty)
            report_mismatch("empty_res", 32'(empty_res), 32'(exp_r.empty));
    endtask

    // called at a rising edge; returns at the edge of the transfer
    task automatic offer_item(action_t op, logic [31:0] v, bit typed, bag_result_t want);
        bag_result_t predicted;
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= op;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_bag_op(op, v);
        awaited_results.insert(awaited_results.size(), typed ? want : predicted);
        op_tally[op]++;
        if (op == ACT_ADD && !predicted.ok)
            full_refusals++;
        if (op == ACT_REMOVE && !predicted.ok)
            remove_misses++;
        if (bag_count > peak_fill)
            peak_fill = bag_count;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (awaited_results.size() == 0);
        @(posedge clk);
    endtask

    // sender
    initial
    begin
        int      pick;
        action_t op;
        logic [31:0] v;

        plan = '{
            '{ACT_QUERY,  32'h0000_0000, 1,  1'b1, '{1'b0, 5'd0,  5'd0,  1'b1}},
            '{ACT_REMOVE, 32'h0000_0005, 1,  1'b1, '{1'b0, 5'd0,  5'd0,  1'b1}},
            '{ACT_CLEAR,  32'h0000_0000, 1,  1'b1, '{1'b1, 5'd0,  5'd0,  1'b1}},
            '{ACT_ADD,    32'h8000_0000, 1,  1'b1, '{1'b1, 5'd0,  5'd1,  1'b0}},
            '{ACT_ADD,    32'h7fff_ffff, 1,  1'b1, '{1'b1, 5'd0,  5'd2,  1'b0}},
            '{ACT_ADD,    32'h7fff_ffff, 1,  1'b1, '{1'b1, 5'd0,  5'd3,  1'b0}},
            '{ACT_ADD,    32'hffff_ffff, 1,  1'b1, '{1'b1, 5'd0,  5'd4,  1'b0}},
            '{ACT_QUERY,  32'h7fff_ffff, 1,  1'b0, '0},
            '{ACT_REMOVE, 32'h7fff_ffff, 1,  1'b0, '0},
            '{ACT_REMOVE, 32'h1234_5678, 1,  1'b0, '0},
            '{ACT_REMOVE, 32'h7fff_ffff, 1,  1'b0, '0},
            '{ACT_QUERY,  32'hffff_ffff, 1,  1'b0, '0},
            '{ACT_ADD,    32'h5555_5555, 14, 1'b0, '0},
            '{ACT_ADD,    32'h0000_0000, 1,  1'b1, '{1'b0, 5'd0,  5'd16, 1'b0}},
            '{ACT_QUERY,  32'h5555_5555, 1,  1'b1, '{1'b1, 5'd14, 5'd16, 1'b0}},
            '{ACT_REMOVE, 32'h8000_0000, 1,  1'b0, '0},
            '{ACT_QUERY,  32'h8000_0000, 1,  1'b0, '0},
            '{ACT_CLEAR,  32'hdead_beef, 1,  1'b1, '{1'b1, 5'd0,  5'd0,  1'b1}}
        };
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
            for (int k = 0; k < plan[r].reps; k++)
                offer_item(plan[r].op, plan[r].val, plan[r].typed, plan[r].want);
        pause_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
                hold_wanted = 1'b1;
            if (n == 500)
                pause_until_drained();
            calm = (n >= 600 && n < 760);
            pick = $urandom_range(99);
            // alternate between filling and draining so both ends are reached
            if ((n / 48) % 2 == 0)
                op = (pick < 58) ? ACT_ADD : (pick < 72) ? ACT_REMOVE :
                     (pick < 98) ? ACT_QUERY : ACT_CLEAR;
            else
                op = (pick < 15) ? ACT_ADD : (pick < 62) ? ACT_REMOVE :
                     (pick < 96) ? ACT_QUERY : ACT_CLEAR;
            v = ($urandom_range(99) < 85) ? value_pool[$urandom_range(7)] : $urandom;
            offer_item(op, v, 1'b0, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        wait (awaited_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d adds (%0d refused when full), %0d removes (%0d misses),",
                 op_tally[ACT_ADD], full_refusals, op_tally[ACT_REMOVE], remove_misses);
        $display("%0d queries, %0d clears; %0d results checked, peak fill %0d of %0d",
                 op_tally[ACT_QUERY], op_tally[ACT_CLEAR], results_checked, peak_fill,
                 BAG_DEPTH);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // receiver
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_result();
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left = HOLDOFF_CYCLES;
            end
            // hold off while the sender keeps offering
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 33);
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

[multiset_bag_table_unit.f]
+incdir+rtl/core
rtl/core/mbt_pkg.sv
rtl/core/mbt_cell.sv
rtl/core/multiset_bag_table_unit.sv
sim/testbench.sv
